>>> hw/rtl/cacfar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cacfar_pkg: shared types and constants of the cell-averaging CFAR detector
// Field widths, register indexes and reset values, and the command word that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package cacfar_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int CELL_INDEX_W = 6;
   localparam int TRAIN_W      = 5;
   localparam int GUARD_W      = 4;
   localparam int GAIN_W       = 16;
   localparam int GAIN_FRAC_W  = 12;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRAINING = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUARD    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN     = 2'd2;

   localparam logic [TRAIN_W-1:0]        TRAINING_RESET = 5'd10;
   localparam logic [GUARD_W-1:0]        GUARD_RESET    = 4'd0;
   localparam logic signed [GAIN_W-1:0]  GAIN_RESET     = 16'sd1143;

   // 1.0 in Q8.8, one bit wider than a sample so that noise + 1.0 cannot wrap
   localparam logic [SAMPLE_W:0] ONE_Q88 = 17'd256;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2
   } acc_op_type;

   typedef struct packed {
      logic                    wr_en;
      logic                    acc_clear;
      acc_op_type              op_a;
      acc_op_type              op_b;
      logic                    launch;
      logic                    short_frame;
      logic                    last_cell;
      logic [CELL_INDEX_W-1:0] cell_index;
   } cfar_cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/cacfar_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cacfar_ctrl: frame sequencer of the CFAR detector
// Counts the samples of a frame in, then walks the cells, issuing two memory
// reads per cycle with the operation that the datapath applies to each.
// ----------------------------------------------------------------------------
module cacfar_ctrl import cacfar_pkg::*; #(
   parameter int FRAME_CAPACITY = 64,
   parameter int MAX_TRAINING   = 16,
   parameter int MAX_GUARD      = 8,
   localparam int ADDR_W = $clog2(FRAME_CAPACITY)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_frame_end,
   input  wire logic [TRAIN_W-1:0] train_eff,
   input  wire logic [GUARD_W-1:0] guard_eff,
   input  wire logic               frame_done,
   output logic                    busy,
   output cfar_cmd_type            cmd,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [ADDR_W-1:0]       rd_addr_a,
   output logic [ADDR_W-1:0]       rd_addr_b
);

   localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
   localparam int PAD_W = TRAIN_W + 1;
   localparam int POS_W = $clog2(2 * FRAME_CAPACITY + MAX_TRAINING + MAX_GUARD + 2) + 1;

   localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);
   localparam logic signed [POS_W-1:0] POS_TWO = POS_W'(2);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_CELL_A = 3'd2;
   localparam logic [2:0] ST_CELL_B = 3'd3;
   localparam logic [2:0] ST_CELL_C = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [ADDR_W-1:0]  cell_ff, cell_in;
   logic [PAD_W-1:0]   dist_ff, dist_in;
   logic [PAD_W-1:0]   pad_ff, pad_in;
   logic [GUARD_W-1:0] guard_ff, guard_in;
   logic               short_ff, short_in;

   logic               accept;
   logic               room;
   logic [CNT_W-1:0]   count_after;
   logic [PAD_W-1:0]   pad_now;
   logic               short_now;
   logic               cell_last;

   logic signed [POS_W-1:0] cell_pos, n_pos, pad_pos, guard_pos, dist_pos;

   // Reflects a position about the frame edges without repeating the edge
   // sample. Only called for frames long enough that one reflection lands
   // inside the frame.
   function automatic logic [ADDR_W-1:0] mirror(input logic signed [POS_W-1:0] p,
                                                 input logic signed [POS_W-1:0] n);
      logic signed [POS_W-1:0] q;
      begin
         q = (p < 0) ? -p : p;
         if (q >= n) begin
            q = n + n - POS_TWO - q;
         end
         return q[ADDR_W-1:0];
      end
   endfunction

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start & ~busy;
   assign room        = (count_ff < CNT_W'(FRAME_CAPACITY));
   assign count_after = room ? (count_ff + CNT_W'(1)) : count_ff;
   assign pad_now     = PAD_W'(train_eff) + PAD_W'(guard_eff);
   assign short_now   = (POS_W'(count_after) < (POS_W'(pad_now) + POS_W'(2)));
   assign cell_last   = ((CNT_W'(cell_ff) + CNT_W'(1)) == n_ff);

   assign cell_pos  = $signed(POS_W'(cell_ff));
   assign n_pos     = $signed(POS_W'(n_ff));
   assign pad_pos   = $signed(POS_W'(pad_ff));
   assign guard_pos = $signed(POS_W'(guard_ff));
   assign dist_pos  = $signed(POS_W'(dist_ff));

   assign wr_addr = count_ff[ADDR_W-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      cell_in   = cell_ff;
      dist_in   = dist_ff;
      pad_in    = pad_ff;
      guard_in  = guard_ff;
      short_in  = short_ff;
      cmd       = '0;
      cmd.op_a  = OP_NONE;
      cmd.op_b  = OP_NONE;
      rd_addr_a = '0;
      rd_addr_b = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.wr_en = room;
               count_in  = count_after;
               if (req_frame_end) begin
                  count_in = '0;
                  n_in     = count_after;
                  pad_in   = pad_now;
                  guard_in = guard_eff;
                  short_in = short_now;
                  cell_in  = '0;
                  dist_in  = PAD_W'(guard_eff) + PAD_W'(1);
                  state_in = short_now ? ST_CELL_A : ST_INIT;
               end
            end
         end
         ST_INIT: begin
            // Window of cell 0: both sides, the left one reflected.
            rd_addr_a     = mirror(-dist_pos, n_pos);
            rd_addr_b     = mirror(dist_pos, n_pos);
            cmd.op_a      = OP_ADD;
            cmd.op_b      = OP_ADD;
            cmd.acc_clear = (dist_ff == (PAD_W'(guard_ff) + PAD_W'(1)));
            if (dist_ff == pad_ff) begin
               state_in = ST_CELL_A;
            end else begin
               dist_in = dist_ff + PAD_W'(1);
            end
         end
         ST_CELL_A: begin
            // Fetch the cell under test and hand its sum on, then start
            // sliding: drop the far left training cell.
            rd_addr_a       = cell_ff;
            cmd.launch      = 1'b1;
            cmd.short_frame = short_ff;
            cmd.last_cell   = cell_last;
            cmd.cell_index  = CELL_INDEX_W'(cell_ff);
            if (!short_ff) begin
               rd_addr_b = mirror(cell_pos - pad_pos, n_pos);
               cmd.op_b  = OP_SUB;
            end
            if (cell_last) begin
               state_in = ST_DRAIN;
            end else if (short_ff) begin
               cell_in = cell_ff + ADDR_W'(1);
            end else begin
               state_in = ST_CELL_B;
            end
         end
         ST_CELL_B: begin
            rd_addr_a = mirror(cell_pos - guard_pos, n_pos);
            rd_addr_b = mirror(cell_pos + guard_pos + POS_ONE, n_pos);
            cmd.op_a  = OP_ADD;
            cmd.op_b  = OP_SUB;
            state_in  = ST_CELL_C;
         end
         ST_CELL_C: begin
            rd_addr_a = mirror(cell_pos + pad_pos + POS_ONE, n_pos);
            cmd.op_a  = OP_ADD;
            cell_in   = cell_ff + ADDR_W'(1);
            state_in  = ST_CELL_A;
         end
         ST_DRAIN: begin
            if (frame_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      cell_ff  <= cell_in;
      dist_ff  <= dist_in;
      pad_ff   <= pad_in;
      guard_ff <= guard_in;
      short_ff <= short_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/cacfar_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cacfar_datapath: sample memory, running window sum and threshold pipeline
// Applies the controller's read commands to a running noise sum and turns
// each launched cell into one result through a four-stage pipeline.
// ----------------------------------------------------------------------------
module cacfar_datapath import cacfar_pkg::*; #(
   parameter int FRAME_CAPACITY = 64,
   parameter int MAX_TRAINING   = 16,
   localparam int ADDR_W = $clog2(FRAME_CAPACITY)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfar_cmd_type             cmd,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [ADDR_W-1:0]        rd_addr_a,
   input  wire logic [ADDR_W-1:0]        rd_addr_b,
   input  wire logic [SAMPLE_W-1:0]      wr_data,
   input  wire logic [TRAIN_W-1:0]       train_eff,
   input  wire logic signed [GAIN_W-1:0] gain,
   output logic                          rsp_valid,
   output logic [CELL_INDEX_W-1:0]       rsp_cell_index,
   output logic                          rsp_detected,
   output logic [SAMPLE_W-1:0]           rsp_noise_estimate,
   output logic                          rsp_short_frame,
   output logic                          rsp_last_cell,
   output logic                          frame_done
);

   localparam int SUM_W   = SAMPLE_W + $clog2(2 * MAX_TRAINING);
   localparam int X_W     = SUM_W - 1;
   localparam int RECIP_W = X_W + 1;
   localparam int PROD_W  = X_W + RECIP_W;
   localparam int QT_W    = SAMPLE_W + TRAIN_W;
   localparam int THR_W   = SAMPLE_W + 2 + GAIN_W;

   typedef struct packed {
      logic [CELL_INDEX_W-1:0] cell_index;
      logic                    short_frame;
      logic                    last_cell;
   } tag_type;

   logic [SAMPLE_W-1:0] mem [FRAME_CAPACITY];
   logic [SAMPLE_W-1:0] dout_a_ff, dout_b_ff;
   cfar_cmd_type        cmd1_ff;

   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    term_a, term_b;

   logic [RECIP_W-1:0]  recip_table [0:MAX_TRAINING];
   logic [RECIP_W-1:0]  recip_ff;

   logic                v1_ff, v2_ff, v3_ff;
   tag_type             tag1_ff, tag2_ff, tag3_ff;
   logic [X_W-1:0]      x1_ff, x2_ff;
   logic [SAMPLE_W-1:0] samp1_ff, samp2_ff, samp3_ff;
   logic [PROD_W-1:0]   prod;
   logic [SAMPLE_W-1:0] q0_ff;
   logic [QT_W-1:0]     qt;
   logic [X_W-1:0]      rem;
   logic                fix;
   logic [SAMPLE_W-1:0] noise3_ff;

   logic signed [THR_W-1:0] thr;
   logic signed [THR_W-1:0] lhs;
   logic                    hit;

   logic                    rsp_valid_ff;
   tag_type                 rsp_tag_ff;
   logic                    rsp_detected_ff;
   logic [SAMPLE_W-1:0]     rsp_noise_ff;

   // Sample memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      dout_a_ff <= mem[rd_addr_a];
      dout_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd1_ff <= '0;
      end else begin
         cmd1_ff <= cmd;
      end
   end

   assign term_a = SUM_W'(dout_a_ff);
   assign term_b = SUM_W'(dout_b_ff);

   always_comb begin
      acc_in = cmd1_ff.acc_clear ? '0 : acc_ff;
      case (cmd1_ff.op_a)
         OP_ADD:  acc_in = acc_in + term_a;
         OP_SUB:  acc_in = acc_in - term_a;
         default: acc_in = acc_in;
      endcase
      case (cmd1_ff.op_b)
         OP_ADD:  acc_in = acc_in + term_b;
         OP_SUB:  acc_in = acc_in - term_b;
         default: acc_in = acc_in;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Reciprocals of the training count, scaled by 2^X_W. The quotient of
   // sum/2 by the training count then comes out at most one short.
   assign recip_table[0] = '0;
   for (genvar Tdiv = 1; Tdiv <= MAX_TRAINING; Tdiv++) begin : g_recip
      assign recip_table[Tdiv] = RECIP_W'((64'd1 << X_W) / Tdiv);
   end

   always_ff @(posedge clock) begin
      recip_ff <= recip_table[train_eff];
   end

   assign prod = PROD_W'(x1_ff) * PROD_W'(recip_ff);
   assign qt   = QT_W'(q0_ff) * QT_W'(train_eff);
   assign rem  = x2_ff - X_W'(qt);
   assign fix  = (rem >= X_W'(train_eff));

   assign thr = $signed({1'b0, ONE_Q88 + (SAMPLE_W + 1)'(noise3_ff)}) * gain;
   assign lhs = $signed(THR_W'({samp3_ff, GAIN_FRAC_W'(0)}));
   assign hit = (lhs > thr);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd1_ff.launch;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      // The sum is halved here so that the divide is by the training count.
      tag1_ff  <= '{cmd1_ff.cell_index, cmd1_ff.short_frame, cmd1_ff.last_cell};
      x1_ff    <= acc_ff[SUM_W-1:1];
      samp1_ff <= dout_a_ff;

      tag2_ff  <= tag1_ff;
      x2_ff    <= x1_ff;
      samp2_ff <= samp1_ff;
      q0_ff    <= prod[X_W +: SAMPLE_W];

      tag3_ff   <= tag2_ff;
      samp3_ff  <= samp2_ff;
      noise3_ff <= q0_ff + SAMPLE_W'(fix);

      rsp_tag_ff      <= tag3_ff;
      rsp_detected_ff <= hit & ~tag3_ff.short_frame;
      rsp_noise_ff    <= tag3_ff.short_frame ? '0 : noise3_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_index     = rsp_tag_ff.cell_index;
   assign rsp_detected       = rsp_detected_ff;
   assign rsp_noise_estimate = rsp_noise_ff;
   assign rsp_short_frame    = rsp_tag_ff.short_frame;
   assign rsp_last_cell      = rsp_tag_ff.last_cell;
   assign frame_done         = rsp_valid_ff & rsp_tag_ff.last_cell;

endmodule
`default_nettype wire

>>> hw/rtl/ca_cfar_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ca_cfar_detector: cell-averaging CFAR detector over one frame of samples
// Loads a frame of Q8.8 magnitudes, then reports per cell the truncated mean
// of the training cells and whether the cell exceeds (noise + 1.0) * gain.
//
//   Channel   Handshake                 Payload
//   request   start in, busy out        req_sample, req_frame_end
//   result    rsp_valid strobe out      rsp_cell_index, rsp_detected,
//                                       rsp_noise_estimate, rsp_short_frame,
//                                       rsp_last_cell
//   csr       csr_write_enable in       csr_index, csr_write_data
//
// A request is taken on every cycle while busy is low, so samples load one
// per cycle. The request that closes the frame raises busy; unless the frame
// is short, the initial window sum (T training cells per side) is built
// first, then each cell goes through the states ST_CELL_A to ST_CELL_C, set
// by the two read ports of the sample memory and the five reads per cell.
// A short frame gives one result per cycle. Results trail the read schedule;
// busy stays high through the last result. Reset is synchronous and clears
// the control state and registers; the sample memory is not cleared. The
// receiver cannot hold results off: each one is on the ports for one cycle.
// ----------------------------------------------------------------------------
module ca_cfar_detector import cacfar_pkg::*; #(
   parameter int FRAME_CAPACITY = 64,
   parameter int MAX_TRAINING   = 16,
   parameter int MAX_GUARD      = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [SAMPLE_W-1:0]     req_sample,
   input  wire logic                    req_frame_end,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_write_data,
   output logic                         rsp_valid,
   output logic [CELL_INDEX_W-1:0]      rsp_cell_index,
   output logic                         rsp_detected,
   output logic [SAMPLE_W-1:0]          rsp_noise_estimate,
   output logic                         rsp_short_frame,
   output logic                         rsp_last_cell
);

   localparam int ADDR_W = $clog2(FRAME_CAPACITY);

   logic [TRAIN_W-1:0]        training_ff, training_in;
   logic [GUARD_W-1:0]        guard_ff, guard_in;
   logic signed [GAIN_W-1:0]  gain_ff, gain_in;

   logic [TRAIN_W-1:0]        train_eff;
   logic [GUARD_W-1:0]        guard_eff;

   cfar_cmd_type              cmd;
   logic [ADDR_W-1:0]         wr_addr, rd_addr_a, rd_addr_b;
   logic                      frame_done;

   // Register writes. An index beyond the three registers is dropped.
   always_comb begin
      training_in = training_ff;
      guard_in    = guard_ff;
      gain_in     = gain_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TRAINING: training_in = csr_write_data[TRAIN_W-1:0];
            CSR_GUARD:    guard_in    = csr_write_data[GUARD_W-1:0];
            CSR_GAIN:     gain_in     = $signed(csr_write_data[GAIN_W-1:0]);
            default:      training_in = training_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         training_ff <= TRAINING_RESET;
         guard_ff    <= GUARD_RESET;
         gain_ff     <= GAIN_RESET;
      end else begin
         training_ff <= training_in;
         guard_ff    <= guard_in;
         gain_ff     <= gain_in;
      end
   end

   // A training count of zero counts as one; both counts saturate at the
   // largest window that the hardware is sized for.
   always_comb begin
      if (training_ff == '0) begin
         train_eff = TRAIN_W'(1);
      end else if (training_ff > TRAIN_W'(MAX_TRAINING)) begin
         train_eff = TRAIN_W'(MAX_TRAINING);
      end else begin
         train_eff = training_ff;
      end
      guard_eff = (guard_ff > GUARD_W'(MAX_GUARD)) ? GUARD_W'(MAX_GUARD) : guard_ff;
   end

   cacfar_ctrl #(
      .FRAME_CAPACITY (FRAME_CAPACITY),
      .MAX_TRAINING   (MAX_TRAINING),
      .MAX_GUARD      (MAX_GUARD)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_frame_end (req_frame_end),
      .train_eff     (train_eff),
      .guard_eff     (guard_eff),
      .frame_done    (frame_done),
      .busy          (busy),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_addr_a     (rd_addr_a),
      .rd_addr_b     (rd_addr_b)
   );

   cacfar_datapath #(
      .FRAME_CAPACITY (FRAME_CAPACITY),
      .MAX_TRAINING   (MAX_TRAINING)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .wr_addr            (wr_addr),
      .rd_addr_a          (rd_addr_a),
      .rd_addr_b          (rd_addr_b),
      .wr_data            (req_sample),
      .train_eff          (train_eff),
      .gain               (gain_ff),
      .rsp_valid          (rsp_valid),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_detected       (rsp_detected),
      .rsp_noise_estimate (rsp_noise_estimate),
      .rsp_short_frame    (rsp_short_frame),
      .rsp_last_cell      (rsp_last_cell),
      .frame_done         (frame_done)
   );

`ifndef ASSERT_OFF
   // Results only appear while a frame is being worked on.
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a frame");

   // The last cell closes the frame: nothing follows it directly.
   a_nothing_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_cell |=> !rsp_valid)
      else $error("result after the last cell of a frame");

   // A short frame never detects and reports no noise.
   a_short_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_frame |-> !rsp_detected && (rsp_noise_estimate == '0))
      else $error("short frame result carries a detection or noise");

   // The request that ends a frame puts the block to work.
   a_close_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_frame_end |=> busy)
      else $error("frame close did not raise busy");
`endif

endmodule
`default_nettype wire

>>> verif/ca_cfar_checker.sv
// ----------------------------------------------------------------------------
// ca_cfar_checker: result predictor and comparator for the CFAR detector
// Watches the request, register and result ports. It keeps its own copy of
// the frame and the settings, works out every cell result when a frame
// closes, and compares each strobed result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module ca_cfar_checker import cacfar_pkg::*; #(
   parameter int FRAME_CAPACITY = 64,
   parameter int MAX_TRAINING   = 16,
   parameter int MAX_GUARD      = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [SAMPLE_W-1:0]     req_sample,
   input  logic                    req_frame_end,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   input  logic                    rsp_valid,
   input  logic [CELL_INDEX_W-1:0] rsp_cell_index,
   input  logic                    rsp_detected,
   input  logic [SAMPLE_W-1:0]     rsp_noise_estimate,
   input  logic                    rsp_short_frame,
   input  logic                    rsp_last_cell,
   output int                      mismatch_count,
   output int                      outstanding_results
);

   typedef struct packed {
      logic [CELL_INDEX_W-1:0] cell_index;
      logic                    detected;
      logic [SAMPLE_W-1:0]     noise_estimate;
      logic                    short_frame;
      logic                    last_cell;
   } cell_verdict_type;

   cell_verdict_type awaited_cells[$];

   logic [SAMPLE_W-1:0]       frame_samples [FRAME_CAPACITY];
   int                        frame_len;
   logic [TRAIN_W-1:0]        training_reg;
   logic [GUARD_W-1:0]        guard_reg;
   logic signed [GAIN_W-1:0]  gain_reg;
   int                        error_total = 0;

   initial begin
      mismatch_count      = 0;
      outstanding_results = 0;
   end

   task automatic report_mismatch(input string msg);
      error_total++;
      $display("CFAR check: %s", msg);
   endtask

   // Positions off either end are reflected about the edge cell, which is
   // not itself repeated.
   function automatic int reflect_position(input int p, input int n);
      if (p < 0) p = -p;
      if (p >= n) p = 2 * n - 2 - p;
      if (p < 0) p = 0;
      if (p >= n) p = n - 1;
      return p;
   endfunction

   task automatic predict_frame_cells();
      int               t;
      int               g;
      int               pad;
      bit               too_short;
      int unsigned      window_sum;
      int unsigned      noise;
      longint           lhs;
      longint           rhs;
      cell_verdict_type verdict;
      t = (training_reg == 0) ? 1 : int'(training_reg);
      if (t > MAX_TRAINING) t = MAX_TRAINING;
      g = (guard_reg > MAX_GUARD) ? MAX_GUARD : int'(guard_reg);
      pad = t + g;
      too_short = frame_len < pad + 2;
      for (int i = 0; i < frame_len; i++) begin
         noise = 0;
         verdict.detected = 1'b0;
         if (!too_short) begin
            window_sum = 0;
            for (int d = g + 1; d <= pad; d++) begin
               window_sum += frame_samples[reflect_position(i - d, frame_len)];
               window_sum += frame_samples[reflect_position(i + d, frame_len)];
            end
            noise = window_sum / (2 * t);
            lhs = longint'(frame_samples[i]) * 4096;
            rhs = longint'(noise + 256) * longint'(gain_reg);
            verdict.detected = lhs > rhs;
         end
         verdict.cell_index     = i[CELL_INDEX_W-1:0];
         verdict.noise_estimate = noise[SAMPLE_W-1:0];
         verdict.short_frame    = too_short;
         verdict.last_cell      = (i == frame_len - 1);
         awaited_cells.push_back(verdict);
      end
      frame_len = 0;
   endtask

   task automatic check_cell();
      cell_verdict_type want;
      if (awaited_cells.size() == 0) begin
         report_mismatch($sformatf("result for cell %0d with none outstanding",
                                   rsp_cell_index));
         return;
      end
      want = awaited_cells.pop_front();
      if (rsp_cell_index !== want.cell_index)
         report_mismatch($sformatf("cell_index got %0d, expected %0d",
                                   rsp_cell_index, want.cell_index));
      if (rsp_detected !== want.detected)
         report_mismatch($sformatf("cell %0d detected got %0d, expected %0d",
                                   want.cell_index, rsp_detected, want.detected));
      if (rsp_noise_estimate !== want.noise_estimate)
         report_mismatch($sformatf("cell %0d noise_estimate got %0d, expected %0d",
                                   want.cell_index, rsp_noise_estimate,
                                   want.noise_estimate));
      if (rsp_short_frame !== want.short_frame)
         report_mismatch($sformatf("cell %0d short_frame got %0d, expected %0d",
                                   want.cell_index, rsp_short_frame,
                                   want.short_frame));
      if (rsp_last_cell !== want.last_cell)
         report_mismatch($sformatf("cell %0d last_cell got %0d, expected %0d",
                                   want.cell_index, rsp_last_cell, want.last_cell));
   endtask

   // Results are checked before the request of the same edge is taken in,
   // since no result can stem from a request accepted at that very edge.
   always @(posedge clock) begin
      if (reset) begin
         frame_len    = 0;
         training_reg = TRAINING_RESET;
         guard_reg    = GUARD_RESET;
         gain_reg     = GAIN_RESET;
         awaited_cells.delete();
      end else begin
         if (rsp_valid) check_cell();
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TRAINING: training_reg = csr_write_data[TRAIN_W-1:0];
               CSR_GUARD:    guard_reg    = csr_write_data[GUARD_W-1:0];
               CSR_GAIN:     gain_reg     = csr_write_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (frame_len < FRAME_CAPACITY) begin
               frame_samples[frame_len] = req_sample;
               frame_len++;
            end
            if (req_frame_end) predict_frame_cells();
         end
      end
      mismatch_count      <= error_total;
      outstanding_results <= awaited_cells.size();
   end

endmodule

>>> verif/ca_cfar_detector_test.sv
// ----------------------------------------------------------------------------
// ca_cfar_detector_test: top-level testbench of the CFAR detector
// Sends frames of samples under a range of training, guard and gain settings,
// first a handful of hand-picked frames and then random ones, with random
// gaps between requests. A checker module beside the block predicts and
// compares every cell result; this module makes the stimulus and the verdict.
// ----------------------------------------------------------------------------
module ca_cfar_detector_test;

   import cacfar_pkg::*;

   // Index 3 is decoded by nobody; a write to it must leave every setting
   // as it was.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam int ITEM_TARGET   = 460;
   // From this many requests on, the sender no longer pauses.
   localparam int CALM_FROM     = 400;
   // Far above the slowest legal run: every request after a full-length gap,
   // every frame closed with the widest window and the most cells.
   localparam int CYCLE_LIMIT   = 200000;
   // Results trail the read schedule through the datapath pipeline; this leaves room.
   localparam int SETTLE_CYCLES = 16;

   typedef enum int {
      SHAPE_CLUTTER,
      SHAPE_FLAT,
      SHAPE_NOISE
   } frame_shape_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [SAMPLE_W-1:0]     req_sample;
   logic                    req_frame_end;
   logic                    csr_write_enable;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;
   logic                    rsp_valid;
   logic [CELL_INDEX_W-1:0] rsp_cell_index;
   logic                    rsp_detected;
   logic [SAMPLE_W-1:0]     rsp_noise_estimate;
   logic                    rsp_short_frame;
   logic                    rsp_last_cell;

   int mismatch_count;
   int outstanding_results;
   int requests_sent = 0;
   int cycle_count   = 0;
   bit pauses_on     = 1'b0;

   ca_cfar_detector i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample         (req_sample),
      .req_frame_end      (req_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_detected       (rsp_detected),
      .rsp_noise_estimate (rsp_noise_estimate),
      .rsp_short_frame    (rsp_short_frame),
      .rsp_last_cell      (rsp_last_cell)
   );

   ca_cfar_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_sample          (req_sample),
      .req_frame_end       (req_frame_end),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_cell_index      (rsp_cell_index),
      .rsp_detected        (rsp_detected),
      .rsp_noise_estimate  (rsp_noise_estimate),
      .rsp_short_frame     (rsp_short_frame),
      .rsp_last_cell       (rsp_last_cell),
      .mismatch_count      (mismatch_count),
      .outstanding_results (outstanding_results)
   );

   always #2 clock = ~clock;

   // Watchdog: a block that stops answering ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offers one request and holds it until the block takes it. While pauses
   // are allowed, a burst of idle cycles may come first, with junk on the
   // payload so that nothing is read while start is low. start stays high
   // from one request to the next when there is no pause.
   task automatic send_request(input logic [SAMPLE_W-1:0] value, input logic closes);
      if (pauses_on && requests_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
         start         <= 1'b0;
         req_sample    <= SAMPLE_W'($urandom);
         req_frame_end <= 1'($urandom);
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start         <= 1'b1;
      req_sample    <= value;
      req_frame_end <= closes;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   // Writes the three settings back to back, optionally followed by a write
   // to the spare index, and lowers the write enable once at the end.
   task automatic load_settings(input logic [CSR_DATA_W-1:0] training_word,
                                input logic [CSR_DATA_W-1:0] guard_word,
                                input logic [CSR_DATA_W-1:0] gain_word,
                                input bit touch_spare);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TRAINING;
      csr_write_data   <= training_word;
      @(posedge clock);
      csr_index        <= CSR_GUARD;
      csr_write_data   <= guard_word;
      @(posedge clock);
      csr_index        <= CSR_GAIN;
      csr_write_data   <= gain_word;
      @(posedge clock);
      if (touch_spare) begin
         csr_index      <= CSR_SPARE;
         csr_write_data <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every predicted result has arrived and the block has
   // dropped busy, then lets it settle so that a register write that follows
   // cannot meet work still in flight.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding_results != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Clutter is a low floor with the odd strong echo, which is where the
   // detector has real decisions to make; the other shapes stress the
   // arithmetic at flat and at full-range input.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input frame_shape_type shape,
                                                       input int level);
      int value;
      case (shape)
         SHAPE_CLUTTER: begin
            if ($urandom_range(0, 7) == 0) value = $urandom_range(16'h0800, 16'hFFFF);
            else value = level + $urandom_range(0, 255);
            if (value > 16'hFFFF) value = 16'hFFFF;
         end
         SHAPE_FLAT:    value = level;
         default:       value = $urandom_range(0, 16'hFFFF);
      endcase
      return value[SAMPLE_W-1:0];
   endfunction

   initial begin
      int               t_set;
      int               g_set;
      int               pad;
      int               frames;
      int               len;
      int               level;
      frame_shape_type  shape;
      logic [15:0]      gain_word;

      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_sample       = '0;
      req_frame_end    = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Settings straight out of reset: a lone full-scale sample closes a
      // frame far too short for ten training cells a side.
      send_request(16'hFFFF, 1'b1);
      drain();

      // A training count of zero counts as one, so three cells are enough.
      // The most negative gain puts the threshold below zero and every cell
      // is detected, even one holding zero.
      load_settings({11'h7FF, 5'd0}, 16'h0000, 16'h8000, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0000, 1'b1);
      repeat (3) send_request(16'hFFFF, 1'b0);
      send_request(16'hFFFF, 1'b1);
      drain();

      // One guard cell, two training cells, the largest gain: the window
      // reflects on both edges of a five-cell frame.
      load_settings(16'd2, 16'd1, 16'h7FFF, 1'b0);
      send_request(16'h0001, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'h8000, 1'b0);
      send_request(16'h00FF, 1'b1);
      drain();

      // Zero gain: a cell is detected when its sample is above zero, and a
      // zero sample sits exactly on the threshold without crossing it.
      load_settings(16'd1, 16'd0, 16'h0000, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'h0001, 1'b0);
      send_request(16'h0000, 1'b1);
      drain();

      // Over-range training and guard counts saturate at sixteen and eight;
      // the spare index is written as well and must change nothing.
      load_settings({11'h5A5, 5'd31}, {12'hA5A, 4'd15}, 16'd1143, 1'b1);
      repeat (3) send_request(pick_sample(SHAPE_NOISE, 0), 1'b0);
      send_request(16'h1234, 1'b1);
      drain();

      // Random part: each pass picks settings, then sends a few whole
      // frames. Most frame lengths lie near the window size, some short of a
      // full window; a few are long, or run past the frame capacity.
      while (requests_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0:       t_set = 0;
            1:       t_set = 1;
            2:       t_set = 16;
            3:       t_set = 31;
            default: t_set = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 4))
            0:       g_set = 0;
            1:       g_set = 8;
            2:       g_set = 15;
            default: g_set = $urandom_range(0, 3);
         endcase
         case ($urandom_range(0, 7))
            0:       gain_word = 16'h8000;
            1:       gain_word = 16'h7FFF;
            2:       gain_word = 16'h0000;
            3, 4, 5: gain_word = 16'($urandom_range(0, 8191));
            default: gain_word = 16'($urandom);
         endcase
         load_settings({11'($urandom_range(0, 2047)), t_set[4:0]},
                       {12'($urandom_range(0, 4095)), g_set[3:0]}, gain_word,
                       $urandom_range(0, 5) == 0);
         pad = ((t_set == 0) ? 1 : (t_set > 16 ? 16 : t_set)) + (g_set > 8 ? 8 : g_set);
         pauses_on = $urandom_range(0, 2) != 0;
         frames = $urandom_range(2, 5);
         for (int f = 0; f < frames && requests_sent < ITEM_TARGET; f++) begin
            case ($urandom_range(0, 19))
               0:       len = $urandom_range(65, 72);
               1, 2, 3: len = $urandom_range(25, 64);
               default: len = $urandom_range(1, pad + 10);
            endcase
            if (len > 72) len = 72;
            case ($urandom_range(0, 5))
               0:       shape = SHAPE_FLAT;
               1:       shape = SHAPE_NOISE;
               default: shape = SHAPE_CLUTTER;
            endcase
            level = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16'hFFFF)
                                                : $urandom_range(0, 2047);
            for (int k = 0; k < len; k++) begin
               send_request(pick_sample(shape, level), k == len - 1);
            end
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
